// ----- src/dot_pkg.sv -----
package dot_pkg;

  localparam int TrigIterationsDefault = 24;

  localparam logic [22:0] HalfTrackReset = 23'd360448;
  localparam logic signed [23:0] BackOffsetReset = -24'sd229376;
  localparam logic [23:0] DriveScaleReset = 24'd585635;
  localparam logic [23:0] TrackScaleReset = 24'd475829;

  localparam logic [1:0] RegHalfTrack = 2'd0;
  localparam logic [1:0] RegBackOffset = 2'd1;
  localparam logic [1:0] RegDriveScale = 2'd2;
  localparam logic [1:0] RegTrackScale = 2'd3;

  localparam logic signed [63:0] PiQ30 = 64'sd3373259426;
  localparam logic signed [63:0] RadToBa = 64'sd683565276;
  localparam logic signed [63:0] CordicGain = 64'sd652032874;
  localparam logic signed [63:0] QuarterTurn = 64'sd1073741824;

  // sinc Taylor coefficients, Q30, highest order first
  function automatic logic signed [63:0] sinc_coef(input logic [2:0] k);
    logic signed [63:0] c;
    begin
      case (k)
        3'd0: c = -64'sd27;
        3'd1: c = 64'sd2959;
        3'd2: c = -64'sd213044;
        3'd3: c = 64'sd8947849;
        3'd4: c = -64'sd178956971;
        default: c = 64'sd1073741824;
      endcase
      return c;
    end
  endfunction

  function automatic logic signed [63:0] atan_ba(input logic [4:0] i);
    logic signed [63:0] v;
    begin
      case (i)
        5'd0: v = 64'sd536870912;
        5'd1: v = 64'sd316933406;
        5'd2: v = 64'sd167458907;
        5'd3: v = 64'sd85004756;
        5'd4: v = 64'sd42667331;
        5'd5: v = 64'sd21354465;
        5'd6: v = 64'sd10679838;
        5'd7: v = 64'sd5340245;
        5'd8: v = 64'sd2670163;
        5'd9: v = 64'sd1335087;
        5'd10: v = 64'sd667544;
        5'd11: v = 64'sd333772;
        5'd12: v = 64'sd166886;
        5'd13: v = 64'sd83443;
        5'd14: v = 64'sd41722;
        5'd15: v = 64'sd20861;
        5'd16: v = 64'sd10430;
        5'd17: v = 64'sd5215;
        5'd18: v = 64'sd2608;
        5'd19: v = 64'sd1304;
        5'd20: v = 64'sd652;
        5'd21: v = 64'sd326;
        5'd22: v = 64'sd163;
        5'd23: v = 64'sd81;
        5'd24: v = 64'sd41;
        5'd25: v = 64'sd20;
        5'd26: v = 64'sd10;
        5'd27: v = 64'sd5;
        5'd28: v = 64'sd3;
        5'd29: v = 64'sd1;
        5'd30: v = 64'sd1;
        default: v = 64'sd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    end
  endfunction

endpackage

// ----- src/dot_mul.sv -----
// Signed multiplier, 64x64 operands, low 64 product bits, built from 32-bit limbs.
module dot_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] p
);
  logic        busy;
  logic [1:0]  step;
  logic        neg;
  logic [63:0] ma, mb;
  logic [63:0] acc;
  logic [31:0] al, bl;
  logic [63:0] part;

  always_comb begin
    al = step[1] ? ma[63:32] : ma[31:0];
    bl = step[0] ? mb[63:32] : mb[31:0];
    part = {32'd0, al} * {32'd0, bl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
        acc <= 64'd0;
        neg <= a[63] ^ b[63];
        ma <= a[63] ? -a : a;
        mb <= b[63] ? -b : b;
      end else if (busy) begin
        unique case (step)
          2'd0: acc <= acc + part;
          2'd1, 2'd2: acc <= acc + {part[31:0], 32'd0};
          default: acc <= acc;
        endcase
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
          p <= neg ? -$signed(acc) : $signed(acc);
        end
      end
    end
  end
endmodule

// ----- src/differential_odometry_tracker_top.sv -----
// Odometry tracker: one request in, one pose/travel result out, one request at a time.
// A request runs 18 multiplies on one shared 32x32 multiplier, a 64-step divider
// (skipped with zero half track) and the CORDIC loop before its result is valid.
// The result register frees the core while a result waits.
// Synchronous active-high rst restores defaults, clears state.
module differential_odometry_tracker_top #(
  parameter int TRIG_ITERATIONS = dot_pkg::TrigIterationsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_front_pos,
  input  logic signed [31:0] left_rear_pos,
  input  logic signed [31:0] right_front_pos,
  input  logic signed [31:0] right_rear_pos,
  input  logic signed [31:0] back_wheel_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic        [31:0] heading,
  output logic signed [31:0] left_travel,
  output logic signed [31:0] right_travel,
  output logic signed [31:0] lateral_travel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  localparam int IterW = $clog2(TRIG_ITERATIONS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MDL, S_MDR, S_MDB, S_SCALE, S_DIV, S_DIVEND, S_PROD, S_ANG,
    S_SINC, S_SIN, S_FWD, S_LAT1, S_LAT2, S_CORDIC, S_PY1, S_PY2, S_PX1, S_PX2, S_DONE
  } state_t;

  state_t state;

  logic [22:0] half_track;
  logic signed [23:0] back_offset;
  logic [23:0] drive_scale, track_scale;

  logic signed [63:0] prev_left_sum, prev_right_sum, prev_back;
  logic signed [63:0] pos_x, pos_y, left_acc, right_acc, lateral_acc;
  logic [31:0] heading_acc;

  logic signed [63:0] dl, dr, db, a, a_ba, h_ba, sinc, sin_q31, fwd, lat, tmp;
  logic signed [63:0] cx, cy, cz;
  logic cflip;
  logic [2:0] hstep;
  logic [IterW-1:0] iter;

  // restoring divider on magnitudes
  logic [63:0] dnum, drem;
  logic [5:0]  dcnt;
  logic        dneg;

  logic mstart, mdone;
  logic signed [63:0] ma, mb, mp;

  dot_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  function automatic logic signed [63:0] asr(input logic signed [63:0] v,
                                             input logic [5:0] n);
    return v >>> n;
  endfunction

  // a config write holds off a request in the same cycle
  assign in_stall = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  logic signed [63:0] lsum_in, rsum_in, back_in;
  assign lsum_in = 64'(left_front_pos) + 64'(left_rear_pos);
  assign rsum_in = 64'(right_front_pos) + 64'(right_rear_pos);
  assign back_in = 64'(back_wheel_pos);

  logic signed [63:0] hx;
  logic [63:0] hmag, dtrial;
  logic [4:0] ai;
  assign hmag = a[63] ? 64'(-a) : 64'(a);
  assign ai = iter[4:0];
  assign dtrial = {drem[62:0], dnum[63]};

  // next Horner term of the sinc polynomial
  logic signed [63:0] poly;
  assign poly = dot_pkg::sinc_coef(hstep) + asr(mp, 6'd30);

  // mid-arc heading, folded by a half turn beyond a quarter turn
  logic [31:0] mid_ang;
  logic signed [63:0] mid_z;
  logic mid_fold;
  assign mid_ang = heading_acc + h_ba[31:0];
  assign mid_z = 64'($signed(mid_ang));
  assign mid_fold = (mid_z > dot_pkg::QuarterTurn) || (mid_z < -dot_pkg::QuarterTurn);

  // result register takes a new pose once the old one is gone
  logic res_load;
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mstart <= 1'b0;
      half_track <= dot_pkg::HalfTrackReset;
      back_offset <= dot_pkg::BackOffsetReset;
      drive_scale <= dot_pkg::DriveScaleReset;
      track_scale <= dot_pkg::TrackScaleReset;
      prev_left_sum <= '0; prev_right_sum <= '0; prev_back <= '0;
      pos_x <= '0; pos_y <= '0; left_acc <= '0; right_acc <= '0; lateral_acc <= '0;
      heading_acc <= '0;
      x_pos <= '0; y_pos <= '0; heading <= '0;
      left_travel <= '0; right_travel <= '0; lateral_travel <= '0;
    end else begin
      mstart <= 1'b0;
      if (res_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dot_pkg::RegHalfTrack:  half_track <= cfg_data[22:0];
          dot_pkg::RegBackOffset: back_offset <= cfg_data[23:0];
          dot_pkg::RegDriveScale: drive_scale <= cfg_data[23:0];
          dot_pkg::RegTrackScale: track_scale <= cfg_data[23:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          ma <= lsum_in - prev_left_sum;
          mb <= 64'(drive_scale);
          mstart <= 1'b1;
          dr <= rsum_in - prev_right_sum;
          db <= back_in - prev_back;
          prev_left_sum <= lsum_in;
          prev_right_sum <= rsum_in;
          prev_back <= back_in;
          state <= S_MDL;
        end
        S_MDL: if (mdone) begin
          dl <= dot_pkg::sat32(asr(mp + 64'sd256, 6'd9));
          ma <= dr; mb <= 64'(drive_scale); mstart <= 1'b1;
          state <= S_MDR;
        end
        S_MDR: if (mdone) begin
          dr <= dot_pkg::sat32(asr(mp + 64'sd256, 6'd9));
          ma <= db; mb <= 64'(track_scale); mstart <= 1'b1;
          state <= S_MDB;
        end
        S_MDB: if (mdone) begin
          db <= dot_pkg::sat32(asr(mp + 64'sd128, 6'd8));
          state <= S_SCALE;
        end
        S_SCALE: begin
          left_acc <= dot_pkg::sat32(left_acc + dl);
          right_acc <= dot_pkg::sat32(right_acc + dr);
          lateral_acc <= dot_pkg::sat32(lateral_acc + db);
          tmp <= (dl - dr) <<< 29;
          dneg <= dl < dr;
          dnum <= (dl < dr) ? 64'(-((dl - dr) <<< 29)) : 64'((dl - dr) <<< 29);
          drem <= '0;
          dcnt <= '0;
          a <= '0;
          state <= (half_track != '0) ? S_DIV : S_PROD;
        end
        S_DIV: begin
          if (dtrial >= 64'(half_track)) begin
            drem <= dtrial - 64'(half_track);
            dnum <= {dnum[62:0], 1'b1};
          end else begin
            drem <= dtrial;
            dnum <= {dnum[62:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) state <= S_DIVEND;
        end
        S_DIVEND: begin
          a <= dneg ? ((64'(dnum) > 64'(dot_pkg::PiQ30)) ? -dot_pkg::PiQ30 : -$signed(dnum))
                    : ((64'(dnum) > 64'(dot_pkg::PiQ30)) ? dot_pkg::PiQ30 : $signed(dnum));
          state <= S_PROD;
        end
        S_PROD: begin
          ma <= a; mb <= dot_pkg::RadToBa; mstart <= 1'b1;
          state <= S_ANG;
        end
        S_ANG: if (mdone) begin
          a_ba <= asr(mp + (64'sd1 <<< 29), 6'd30);
          h_ba <= asr(mp + (64'sd1 <<< 30), 6'd31);
          ma <= $signed(hmag); mb <= $signed(hmag); mstart <= 1'b1;
          hstep <= 3'd0;
          state <= S_SINC;
        end
        S_SINC: if (mdone) begin
          if (hstep == 3'd0) begin
            hx <= $signed(64'(mp) >> 32);
            ma <= dot_pkg::sinc_coef(3'd0);
            mb <= $signed(64'(mp) >> 32);
            mstart <= 1'b1;
            hstep <= 3'd1;
          end else begin
            if (hstep == 3'd5) begin
              sinc <= poly;
              ma <= a; mb <= poly; mstart <= 1'b1;
              state <= S_SIN;
            end else begin
              ma <= poly; mb <= hx; mstart <= 1'b1;
              hstep <= hstep + 3'd1;
            end
          end
        end
        S_SIN: if (mdone) begin
          sin_q31 <= asr(mp, 6'd30);
          ma <= dl + dr; mb <= sinc; mstart <= 1'b1;
          state <= S_FWD;
        end
        S_FWD: if (mdone) begin
          fwd <= asr(mp, 6'd31);
          ma <= db; mb <= sinc; mstart <= 1'b1;
          state <= S_LAT1;
        end
        S_LAT1: if (mdone) begin
          lat <= asr(mp, 6'd30);
          ma <= 64'(back_offset); mb <= sin_q31; mstart <= 1'b1;
          state <= S_LAT2;
        end
        S_LAT2: if (mdone) begin
          lat <= lat + asr(mp, 6'd30);
          cflip <= mid_fold;
          cz <= mid_fold ? 64'($signed(mid_ang + 32'h80000000)) : mid_z;
          cx <= dot_pkg::CordicGain;
          cy <= '0;
          iter <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (iter == IterW'(TRIG_ITERATIONS)) begin
            if (cflip) begin
              cx <= -cx; cy <= -cy;
            end
            state <= S_PY1;
          end else begin
            if (cz >= 0) begin
              cx <= cx - asr(cy, 6'(ai));
              cy <= cy + asr(cx, 6'(ai));
              cz <= cz - dot_pkg::atan_ba(ai);
            end else begin
              cx <= cx + asr(cy, 6'(ai));
              cy <= cy - asr(cx, 6'(ai));
              cz <= cz + dot_pkg::atan_ba(ai);
            end
            iter <= iter + IterW'(1);
          end
        end
        S_PY1: begin
          ma <= fwd; mb <= cx; mstart <= 1'b1;
          state <= S_PY2;
          hstep <= 3'd0;
        end
        S_PY2: if (mdone) begin
          if (hstep == 3'd0) begin
            tmp <= mp;
            ma <= lat; mb <= cy; mstart <= 1'b1;
            hstep <= 3'd1;
          end else begin
            pos_y <= dot_pkg::sat32(pos_y + asr(tmp - mp, 6'd30));
            ma <= fwd; mb <= cy; mstart <= 1'b1;
            hstep <= 3'd0;
            state <= S_PX1;
          end
        end
        S_PX1: if (mdone) begin
          tmp <= mp;
          ma <= lat; mb <= cx; mstart <= 1'b1;
          state <= S_PX2;
        end
        S_PX2: if (mdone) begin
          pos_x <= dot_pkg::sat32(pos_x + asr(tmp + mp, 6'd30));
          heading_acc <= heading_acc + a_ba[31:0];
          state <= S_DONE;
        end
        S_DONE: if (res_load) begin
          x_pos <= pos_x[31:0];
          y_pos <= pos_y[31:0];
          heading <= heading_acc;
          left_travel <= left_acc[31:0];
          right_travel <= right_acc[31:0];
          lateral_travel <= lateral_acc[31:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> (state == S_IDLE)) else $error("cfg while busy");
endmodule
